// File: hdl/pte_pkg.sv
// Shared types, constants and address helpers for the prefix trie engine.
package pte_pkg;

    // Table geometry
    localparam int NODE_COUNT    = 1024;
    localparam int ALPHABET_SIZE = 26;
    localparam int NODE_W        = $clog2(NODE_COUNT);
    localparam int PTR_W         = NODE_W + 1;
    localparam int SLOT_DEPTH    = NODE_COUNT * ALPHABET_SIZE;
    localparam int SLOT_W        = $clog2(SLOT_DEPTH);

    // Request field widths
    localparam int OP_W     = 2;
    localparam int LETTER_W = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_PREFIX = 2'd2;

    // Letter code of the empty word; any code at or above it takes no step
    localparam logic [LETTER_W-1:0] LETTER_EMPTY = LETTER_W'(ALPHABET_SIZE);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_FIN
    } t_state;

    // Child table address of one node and one letter
    function automatic logic [SLOT_W-1:0] slot_of(input logic [NODE_W-1:0] node,
                                                  input logic [LETTER_W-1:0] letter);
        logic [SLOT_W-1:0] base;
        base = SLOT_W'(node) * SLOT_W'(ALPHABET_SIZE);
        return base + SLOT_W'(letter);
    endfunction

endpackage

// File: hdl/pte_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module pte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; hold data when not reading
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/prefix_trie_engine.sv
// Top level of the prefix trie engine: walk control, node allocation and result register.
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ------------------------------------
//  in        input      i_in_valid / o_in_stall    i_op, i_letter, i_last_letter
//  out       output     o_out_valid / i_out_stall  o_found, o_status
//
// A letter that is not the last of its word reads the child table at the current node
// in the idle state, then follows or allocates the link in the step state; the last letter
// also passes the finish state, which loads the result from the end mark read in the step state.
// The registered child table read sets this order; each letter depends on the previous link.
// After reset a clearing pass zeroes both tables, stalling the input.
// A held result blocks the next one in the finish state until the output register frees.
module prefix_trie_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [pte_pkg::OP_W-1:0]       i_op,
    input  logic [pte_pkg::LETTER_W-1:0]   i_letter,
    input  logic                           i_last_letter,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_found,
    output logic                           o_status
);

    // Control state
    pte_pkg::t_state                  r_state, n_state;
    logic [pte_pkg::SLOT_W-1:0]       r_clr, n_clr;
    logic [pte_pkg::NODE_W-1:0]       r_cur, n_cur;
    logic [pte_pkg::PTR_W-1:0]        r_next_free, n_next_free;
    logic                             r_missing, n_missing;
    logic                             r_overflow, n_overflow;
    logic                             r_out_valid, n_out_valid;

    // Payload registers
    logic [pte_pkg::OP_W-1:0]         r_op;
    logic [pte_pkg::LETTER_W-1:0]     r_letter;
    logic                             r_last;
    logic                             r_found, n_found;
    logic                             r_status, n_status;

    // Memory ports
    logic                             ch_we, ch_re;
    logic [pte_pkg::SLOT_W-1:0]       ch_waddr, ch_raddr;
    logic [pte_pkg::NODE_W-1:0]       ch_wdata, ch_rdata;
    logic                             end_we, end_re;
    logic [pte_pkg::NODE_W-1:0]       end_waddr, end_raddr;
    logic                             end_wdata, end_rdata;

    // Walk step results
    logic                             in_acc;
    logic                             out_free;
    logic                             is_insert;
    logic                             s_letter_ok;
    logic                             s_alloc;
    logic [pte_pkg::NODE_W-1:0]       s_node;
    logic                             s_missing;
    logic                             s_overflow;

    assign in_acc    = i_in_valid && (r_state == pte_pkg::ST_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign is_insert = (r_op == pte_pkg::OP_INSERT);

    pte_ram #(
        .WIDTH (pte_pkg::NODE_W),
        .DEPTH (pte_pkg::SLOT_DEPTH)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (ch_we),
        .i_waddr (ch_waddr),
        .i_wdata (ch_wdata),
        .i_re    (ch_re),
        .i_raddr (ch_raddr),
        .o_rdata (ch_rdata)
    );

    pte_ram #(
        .WIDTH (1),
        .DEPTH (pte_pkg::NODE_COUNT)
    ) u_end_ram (
        .i_clk   (i_clk),
        .i_we    (end_we),
        .i_waddr (end_waddr),
        .i_wdata (end_wdata),
        .i_re    (end_re),
        .i_raddr (end_raddr),
        .o_rdata (end_rdata)
    );

    // Follow or allocate one link from the child read
    always_comb begin
        s_letter_ok = (r_letter < pte_pkg::LETTER_EMPTY);
        s_alloc     = 1'b0;
        s_node      = r_cur;
        s_missing   = r_missing;
        s_overflow  = r_overflow;
        if (s_letter_ok) begin
            if (is_insert) begin
                if (!r_overflow) begin
                    if (ch_rdata == '0) begin
                        if (r_next_free < pte_pkg::PTR_W'(pte_pkg::NODE_COUNT)) begin
                            s_alloc = 1'b1;
                            s_node  = r_next_free[pte_pkg::NODE_W-1:0];
                        end else begin
                            s_overflow = 1'b1;
                        end
                    end else begin
                        s_node = ch_rdata;
                    end
                end
            end else if (!r_missing) begin
                if (ch_rdata == '0) begin
                    s_missing = 1'b1;
                end else begin
                    s_node = ch_rdata;
                end
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pte_pkg::ST_CLEAR: begin
                if (r_clr == pte_pkg::SLOT_W'(pte_pkg::SLOT_DEPTH - 1)) begin
                    n_state = pte_pkg::ST_IDLE;
                end
            end
            pte_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = pte_pkg::ST_STEP;
                end
            end
            pte_pkg::ST_STEP: begin
                n_state = r_last ? pte_pkg::ST_FIN : pte_pkg::ST_IDLE;
            end
            pte_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = pte_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pte_pkg::ST_CLEAR;
            end
        endcase
    end

    // Memory controls and input stall
    always_comb begin
        o_in_stall = (r_state != pte_pkg::ST_IDLE);
        ch_we      = 1'b0;
        ch_waddr   = pte_pkg::slot_of(r_cur, s_letter_ok ? r_letter : '0);
        ch_wdata   = s_node;
        ch_re      = in_acc;
        ch_raddr   = pte_pkg::slot_of(r_cur,
                         (i_letter < pte_pkg::LETTER_EMPTY) ? i_letter : '0);
        end_we     = 1'b0;
        end_waddr  = s_node;
        end_wdata  = 1'b1;
        end_re     = 1'b0;
        end_raddr  = s_node;
        case (r_state)
            pte_pkg::ST_CLEAR: begin
                ch_we     = 1'b1;
                ch_waddr  = r_clr;
                ch_wdata  = '0;
                end_we    = 1'b1;
                end_waddr = r_clr[pte_pkg::NODE_W-1:0];
                end_wdata = 1'b0;
            end
            pte_pkg::ST_STEP: begin
                ch_we  = s_alloc;
                end_we = r_last && is_insert && !s_overflow;
                end_re = r_last;
            end
            default: begin
                ch_we = 1'b0;
            end
        endcase
    end

    // Walk registers and result
    always_comb begin
        n_clr       = r_clr;
        n_cur       = r_cur;
        n_next_free = r_next_free;
        n_missing   = r_missing;
        n_overflow  = r_overflow;
        n_out_valid = r_out_valid && i_out_stall;
        n_found     = r_found;
        n_status    = r_status;
        case (r_state)
            pte_pkg::ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
            end
            pte_pkg::ST_STEP: begin
                n_cur      = s_node;
                n_missing  = s_missing;
                n_overflow = s_overflow;
                if (s_alloc) begin
                    n_next_free = r_next_free + 1'b1;
                end
            end
            pte_pkg::ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (is_insert) begin
                        n_found  = 1'b0;
                        n_status = r_overflow;
                    end else if (r_op == pte_pkg::OP_SEARCH) begin
                        n_found  = !r_missing && end_rdata;
                        n_status = 1'b0;
                    end else begin
                        n_found  = !r_missing;
                        n_status = 1'b0;
                    end
                    n_cur      = '0;
                    n_missing  = 1'b0;
                    n_overflow = 1'b0;
                end
            end
            default: begin
                n_clr = r_clr;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pte_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_cur       <= '0;
            r_next_free <= pte_pkg::PTR_W'(1);
            r_missing   <= 1'b0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cur       <= n_cur;
            r_next_free <= n_next_free;
            r_missing   <= n_missing;
            r_overflow  <= n_overflow;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: capture the request, hold the result
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= i_op;
            r_letter <= i_letter;
            r_last   <= i_last_letter;
        end
        r_found  <= n_found;
        r_status <= n_status;
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_status    = r_status;

    // Allocation never runs past the node pool
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= pte_pkg::PTR_W'(pte_pkg::NODE_COUNT))
        else $error("node allocation ran past the pool");

    // A new result appears only out of the finish state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == pte_pkg::ST_FIN))
        else $error("result raised outside the finish state");

    // A finished word leaves the walk at the root with clean flags
    a_walk_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state == pte_pkg::ST_FIN) && r_state == pte_pkg::ST_IDLE) |->
            (r_cur == '0 && !r_missing && !r_overflow))
        else $error("walk not rewound after a result");

    // A link written during a walk never points at the root
    a_link_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ch_we && r_state == pte_pkg::ST_STEP) |-> (ch_wdata != '0))
        else $error("allocated link points at the root");

endmodule
